// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/bcmp_pkg.sv
`timescale 1ns / 1ps
package bcmp_pkg;

  localparam int NW  = 15;  // n width
  localparam int KW  = 16;  // k width
  localparam int VW  = 31;  // residue width
  localparam int DW  = 33;  // signed Bezout coefficient width

  localparam logic [VW-1:0] MOD_RESET = 31'd1000000007;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CAP = 2'd1,
    ST_MOD = 2'd2
  } status_code_t;

  typedef struct packed {
    logic                 kind;
    logic [NW-1:0]        total_count;
    logic signed [KW-1:0] chosen_count;
  } query_t;

  typedef struct packed {
    logic [VW-1:0] value;
    logic [1:0]    status;
  } result_t;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MSEL_FWD,    // acc * i, building factorials
    MSEL_BWD,    // acc * i, building inverse factorials
    MSEL_LOOK1,  // n! * inv((n-k)!)
    MSEL_LOOK2   // acc * inv(k!)
  } mul_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_CAP,
    RES_MOD,
    RES_VALUE
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     seed_fwd;
    logic     acc_fact;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     fwd_commit;
    logic     inv_go;
    logic     inv_commit;
    logic     bwd_commit;
    logic     built_commit;
    logic     rd_look1;
    logic     rd_look2;
    logic     look_acc;
    logic     emit;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic kbad;
    logic ncap;
    logic nmod;
    logic nhit;
    logic fwd_last;
    logic bwd_more;
    logic kind;
    logic mul_done;
    logic inv_done;
    logic inv_ok;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FWD_LOAD,
    S_FWD_GO,
    S_FWD_WAIT,
    S_INV_GO,
    S_INV_WAIT,
    S_BWD_CHK,
    S_BWD_WAIT,
    S_LOOK_A,
    S_LOOK_W1,
    S_LOOK_B,
    S_LOOK_W2
  } ctrl_state_t;

  typedef enum logic [2:0] {
    INV_IDLE,
    INV_TEST,
    INV_DIV,
    INV_UPD,
    INV_FIN
  } inv_state_t;

endpackage

// File: hw/rtl/bcmp_mulmod.sv
`timescale 1ns / 1ps
// Bit-serial modular multiply: one bit of b per cycle, MSB first.
module bcmp_mulmod
  import bcmp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [VW-1:0] a,
  input  logic [VW-1:0] b,
  input  logic [VW-1:0] m,
  output logic          done,
  output logic [VW-1:0] res
);

  logic          run;
  logic [4:0]    cnt;
  logic [VW-1:0] a_r;
  logic [VW-1:0] b_sh;
  logic [VW-1:0] r;
  logic [VW:0]   m_x;
  logic [VW:0]   t_dbl;
  logic [VW:0]   t_red;
  logic [VW:0]   t_add;
  logic [VW:0]   t_fin;

  // r = (2r + bit*a) mod m, with two conditional subtracts
  always_comb begin
    m_x   = {1'b0, m};
    t_dbl = {r, 1'b0};
    t_red = (t_dbl >= m_x) ? t_dbl - m_x : t_dbl;
    t_add = t_red + (b_sh[VW-1] ? {1'b0, a_r} : '0);
    t_fin = (t_add >= m_x) ? t_add - m_x : t_add;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 5'(VW - 1);
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and running remainder
  always_ff @(posedge clk) begin
    if (go) begin
      a_r  <= a;
      b_sh <= b;
      r    <= '0;
    end else if (run) begin
      b_sh <= {b_sh[VW-2:0], 1'b0};
      r    <= t_fin[VW-1:0];
    end
  end

  assign res = r;

endmodule

// File: hw/rtl/bcmp_inv.sv
`timescale 1ns / 1ps
// Extended Euclid inverse. Each quotient is found by restoring division,
// one bit per cycle, while q*t1 accumulates alongside.
module bcmp_inv
  import bcmp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [VW-1:0] a,
  input  logic [VW-1:0] m,
  output logic          done,
  output logic          ok,
  output logic [VW-1:0] inv
);

  inv_state_t    state, state_next;
  logic [4:0]    cnt;
  logic [VW-1:0] r0, r1, dv, rem;
  logic [DW-1:0] t0, t1, qt;
  logic [VW:0]   rr;
  logic          ge;
  logic [VW:0]   rr_sub;
  logic [DW-1:0] t0_pos;

  always_comb begin
    rr     = {rem, dv[VW-1]};
    ge     = rr >= {1'b0, r1};
    rr_sub = rr - {1'b0, r1};
    t0_pos = t0 + DW'(m);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= INV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      INV_IDLE: if (go) state_next = INV_TEST;
      INV_TEST: state_next = (r1 == '0) ? INV_FIN : INV_DIV;
      INV_DIV:  if (cnt == '0) state_next = INV_UPD;
      INV_UPD:  state_next = INV_TEST;
      INV_FIN:  state_next = INV_IDLE;
      default:  state_next = INV_IDLE;
    endcase
  end

  // done strobe and division counter
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= (state == INV_FIN);
      if (state == INV_TEST) begin
        cnt <= 5'(VW - 1);
      end else if (state == INV_DIV) begin
        cnt <= cnt - 5'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      INV_IDLE: begin
        if (go) begin
          r0 <= m;
          r1 <= a;
          t0 <= '0;
          t1 <= DW'(1);
        end
      end
      INV_TEST: begin
        dv  <= r0;
        rem <= '0;
        qt  <= '0;
      end
      INV_DIV: begin
        dv  <= {dv[VW-2:0], 1'b0};
        rem <= ge ? rr_sub[VW-1:0] : rr[VW-1:0];
        qt  <= {qt[DW-2:0], 1'b0} + (ge ? t1 : '0);
      end
      INV_UPD: begin
        r0 <= r1;
        r1 <= rem;
        t0 <= t1;
        t1 <= t0 - qt;
      end
      INV_FIN: begin
        ok  <= (r0 == VW'(1));
        inv <= t0[DW-1] ? t0_pos[VW-1:0] : t0[VW-1:0];
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/bcmp_dp.sv
`timescale 1ns / 1ps
// Datapath: modulus, factorial tables, query registers, arithmetic units.
module bcmp_dp
  import bcmp_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
)
(
  input  logic          clk,
  input  logic          rst,
  input  query_t        query,
  input  logic          cfg_we,
  input  logic [VW-1:0] cfg_data,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat,
  output result_t       result,
  output logic          done
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [VW-1:0] modulus;
  logic [AW-1:0] built;
  query_t        q;
  logic [NW-1:0] i;
  logic [VW-1:0] acc;

  logic [VW-1:0] fact_mem  [TABLE_DEPTH];
  logic [VW-1:0] ifact_mem [TABLE_DEPTH];
  logic [VW-1:0] fact_rdata, ifact_rdata;
  logic          fact_rzero, ifact_rzero;
  logic [VW-1:0] fact_val, ifact_val;

  logic [NW-1:0] k_u;
  logic [NW-1:0] fact_raddr, ifact_raddr;
  logic          fact_re, ifact_re;

  logic          mul_go, mul_done;
  logic [VW-1:0] mul_a, mul_b, mul_res;
  logic          inv_done, inv_ok;
  logic [VW-1:0] inv_val;

  assign k_u       = q.chosen_count[NW-1:0];
  assign fact_val  = fact_rzero  ? VW'(1) : fact_rdata;
  assign ifact_val = ifact_rzero ? VW'(1) : ifact_rdata;

  // modulus register and built-up marker
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
      built   <= '0;
    end else if (cfg_we) begin
      modulus <= cfg_data;
      built   <= '0;
    end else if (cmd.built_commit) begin
      built   <= AW'(q.total_count);
    end
  end

  // query, index and accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) q <= query;
    priority if (cmd.seed_fwd) begin
      i <= NW'(32'(built) + 32'd1);
    end else if (cmd.fwd_commit) begin
      i <= i + NW'(1);
    end else if (cmd.inv_commit) begin
      i <= q.total_count;
    end else if (cmd.bwd_commit) begin
      i <= i - NW'(1);
    end
    priority if (cmd.acc_fact) begin
      acc <= fact_val;
    end else if (cmd.inv_commit) begin
      acc <= inv_val;
    end else if (cmd.fwd_commit || cmd.bwd_commit || cmd.look_acc) begin
      acc <= mul_res;
    end
  end

  // table read addresses
  always_comb begin
    fact_re     = cmd.seed_fwd || cmd.rd_look1;
    fact_raddr  = cmd.seed_fwd ? NW'(built) : q.total_count;
    ifact_re    = cmd.rd_look1 || cmd.rd_look2;
    ifact_raddr = cmd.rd_look1 ? q.total_count - k_u : k_u;
  end

  // factorial table; entry 0 is implied as one and never written
  always_ff @(posedge clk) begin
    if (cmd.fwd_commit) fact_mem[AW'(i)] <= mul_res;
    if (fact_re) begin
      fact_rdata <= fact_mem[AW'(fact_raddr)];
      fact_rzero <= (fact_raddr == '0);
    end
  end

  // inverse factorial table
  always_ff @(posedge clk) begin
    if (cmd.inv_commit) begin
      ifact_mem[AW'(q.total_count)] <= inv_val;
    end else if (cmd.bwd_commit) begin
      ifact_mem[AW'(i - NW'(1))] <= mul_res;
    end
    if (ifact_re) begin
      ifact_rdata <= ifact_mem[AW'(ifact_raddr)];
      ifact_rzero <= (ifact_raddr == '0);
    end
  end

  // multiplier operands
  always_comb begin
    mul_go = cmd.mul_go;
    unique case (cmd.mul_sel)
      MSEL_FWD, MSEL_BWD: begin
        mul_a = acc;
        mul_b = VW'(i);
      end
      MSEL_LOOK1: begin
        mul_a = fact_val;
        mul_b = ifact_val;
      end
      MSEL_LOOK2: begin
        mul_a = acc;
        mul_b = ifact_val;
      end
      default: begin
        mul_a = acc;
        mul_b = ifact_val;
      end
    endcase
  end

  bcmp_mulmod u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .m    (modulus),
    .done (mul_done),
    .res  (mul_res)
  );

  bcmp_inv u_inv (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.inv_go),
    .a    (acc),
    .m    (modulus),
    .done (inv_done),
    .ok   (inv_ok),
    .inv  (inv_val)
  );

  // status toward the controller
  always_comb begin
    stat.kbad     = q.chosen_count[KW-1] || (k_u > q.total_count);
    stat.ncap     = 32'(q.total_count) > 32'(TABLE_DEPTH - 1);
    stat.nmod     = VW'(q.total_count) >= modulus;
    stat.nhit     = 32'(q.total_count) <= 32'(built);
    stat.fwd_last = (i == q.total_count);
    stat.bwd_more = 32'(i) > 32'(built) + 32'd1;
    stat.kind     = q.kind;
    stat.mul_done = mul_done;
    stat.inv_done = inv_done;
    stat.inv_ok   = inv_ok;
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.res_sel)
        RES_ZERO: begin
          result.value  <= '0;
          result.status <= ST_OK;
        end
        RES_CAP: begin
          result.value  <= '0;
          result.status <= ST_CAP;
        end
        RES_MOD: begin
          result.value  <= '0;
          result.status <= ST_MOD;
        end
        RES_VALUE: begin
          result.value  <= mul_res;
          result.status <= ST_OK;
        end
        default: begin
          result.value  <= '0;
          result.status <= ST_OK;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/bcmp_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences checks, table extension and lookup.
module bcmp_ctrl
  import bcmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.kbad) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_ZERO;
          state_next  = S_IDLE;
        end else if (stat.ncap) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_CAP;
          state_next  = S_IDLE;
        end else if (stat.nmod) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_MOD;
          state_next  = S_IDLE;
        end else if (stat.nhit) begin
          cmd.rd_look1 = 1'b1;
          state_next   = S_LOOK_A;
        end else begin
          cmd.seed_fwd = 1'b1;
          state_next   = S_FWD_LOAD;
        end
      end
      S_FWD_LOAD: begin
        cmd.acc_fact = 1'b1;
        state_next   = S_FWD_GO;
      end
      S_FWD_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MSEL_FWD;
        state_next  = S_FWD_WAIT;
      end
      S_FWD_WAIT: begin
        if (stat.mul_done) begin
          cmd.fwd_commit = 1'b1;
          state_next     = stat.fwd_last ? S_INV_GO : S_FWD_GO;
        end
      end
      S_INV_GO: begin
        cmd.inv_go = 1'b1;
        state_next = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        if (stat.inv_done) begin
          if (stat.inv_ok) begin
            cmd.inv_commit = 1'b1;
            state_next     = S_BWD_CHK;
          end else begin
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_MOD;
            state_next  = S_IDLE;
          end
        end
      end
      S_BWD_CHK: begin
        if (stat.bwd_more) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MSEL_BWD;
          state_next  = S_BWD_WAIT;
        end else begin
          cmd.built_commit = 1'b1;
          cmd.rd_look1     = 1'b1;
          state_next       = S_LOOK_A;
        end
      end
      S_BWD_WAIT: begin
        if (stat.mul_done) begin
          cmd.bwd_commit = 1'b1;
          state_next     = S_BWD_CHK;
        end
      end
      S_LOOK_A: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MSEL_LOOK1;
        state_next  = S_LOOK_W1;
      end
      S_LOOK_W1: begin
        if (stat.mul_done) begin
          if (stat.kind) begin
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_VALUE;
            state_next  = S_IDLE;
          end else begin
            cmd.look_acc = 1'b1;
            cmd.rd_look2 = 1'b1;
            state_next   = S_LOOK_B;
          end
        end
      end
      S_LOOK_B: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MSEL_LOOK2;
        state_next  = S_LOOK_W2;
      end
      S_LOOK_W2: begin
        if (stat.mul_done) begin
          cmd.emit    = 1'b1;
          cmd.res_sel = RES_VALUE;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/binomial_coefficient_mod_prime.sv
`timescale 1ns / 1ps
// C(n,k) or P(n,k) modulo a programmable prime, from lazily grown
// factorial and inverse factorial tables.
// Input: a query beat is taken on a rising edge with start high and busy low.
// Output: each result beat is shown for one cycle with done high; the
// receiver cannot stall it. One result per query, in order.
// Config: cfg_we writes the modulus (cfg_data) and clears the built tables;
// write only while busy is low and no result is pending.
// Work per query: a query rejected by range checks (k outside 0..n, n past the
// table, n not below the modulus) is answered straight from the check state.
// A table hit costs one serial modular multiply for P(n,k) and two for C(n,k).
// Extending the tables costs one multiply per new entry on each of the
// forward and backward passes, plus one Euclid inverse, which runs one
// restoring division per quotient step. One query is in flight at a time.
// Reset: modulus goes to 1000000007, tables count as empty, no beat pending.
module binomial_coefficient_mod_prime
  import bcmp_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
)
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  query_t        query,
  output logic          busy,
  output logic          done,
  output result_t       result,
  input  logic          cfg_we,
  input  logic [VW-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bcmp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bcmp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .query    (query),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .result   (result),
    .done     (done)
  );

endmodule

// File: hw/rtl/bcmp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks on the top level.
module bcmp_checker
  import bcmp_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  // an accepted query keeps the block busy
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // result beats are single-cycle and never adjacent
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  // an error status carries a zero value
  `ASSERT_IMPLIES(a_err_zero, clk, rst, done && (result.status != ST_OK), result.value == '0)
  // status code is one of ok, capacity, modulus
  `ASSERT_IMPLIES(a_status_code, clk, rst, done, result.status <= ST_MOD)

endmodule

bind binomial_coefficient_mod_prime bcmp_checker u_bcmp_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
